### sv/uud_pkg.sv
// ----------------------------------------------------------------------------
// uud_pkg
// Shared constants, result codes and types of the uudecode body decoder.
// ----------------------------------------------------------------------------
package uud_pkg;

    // line store
    localparam int LINE_CHARS = 63;
    localparam int CNT_W      = $clog2(LINE_CHARS + 1);
    localparam int SLOT_W     = $clog2(LINE_CHARS);
    localparam int NUM_BUFS   = 4;
    localparam int BUF_W      = $clog2(NUM_BUFS);
    localparam int ADDR_W     = BUF_W + SLOT_W;
    localparam int RAM_DEPTH  = NUM_BUFS * (2 ** SLOT_W);

    // read position in a line: groups of a 63-byte line reach position 84
    localparam int POS_W      = 7;

    // line job queue
    localparam int Q_DEPTH    = 2;
    localparam int Q_IDX_W    = $clog2(Q_DEPTH);
    localparam int Q_NUM_W    = $clog2(Q_DEPTH + 1);

    // result kinds
    localparam logic [2:0] K_DATA      = 3'd0;
    localparam logic [2:0] K_FINISHED  = 3'd1;
    localparam logic [2:0] K_PREMATURE = 3'd2;
    localparam logic [2:0] K_ILLEGAL   = 3'd3;
    localparam logic [2:0] K_MARKER    = 3'd4;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_BTICK = 8'h60;
    localparam logic [7:0] CH_HIGH  = 8'h80;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] MAX_LEN  = 8'd63;

    // one finished line handed from front to back
    typedef struct packed {
        logic             eoi;
        logic [CNT_W-1:0] cnt;
        logic [BUF_W-1:0] bsel;
    } t_job;

    // line store write port
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr;

endpackage

### sv/uud_stream_if.sv
// ----------------------------------------------------------------------------
// uud_stream_if
// Valid/ready channels: character requests in, decoded results out.
// ----------------------------------------------------------------------------
interface uud_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_input;

    modport source (output valid, output char_in, output end_of_input, input ready);
    modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

interface uud_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output kind, output data_byte, output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input last, output ready);
endinterface

### sv/uud_ram.sv
// ----------------------------------------------------------------------------
// uud_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module uud_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### sv/uud_front.sv
// ----------------------------------------------------------------------------
// uud_front
// Takes character requests, gathers line characters into a rotating set of
// line buffers and posts a job for every line end or end of input.
// ----------------------------------------------------------------------------
module uud_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    uud_in_if.sink        i_in,
    output uud_pkg::t_wr  o_wr,
    output logic          o_push,
    output uud_pkg::t_job o_job,
    input  logic          i_full
);
    import uud_pkg::*;

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [BUF_W-1:0] r_bsel, n_bsel;
    logic             acc;
    logic             is_nl;

    assign i_in.ready = !i_full;
    assign acc        = i_in.valid && !i_full;
    assign is_nl      = (i_in.char_in == CH_LF) || (i_in.char_in == CH_CR);

    always_comb begin
        n_cnt       = r_cnt;
        n_bsel      = r_bsel;
        o_push      = 1'b0;
        o_wr.we     = 1'b0;
        o_wr.addr   = {r_bsel, r_cnt[SLOT_W-1:0]};
        o_wr.data   = i_in.char_in;
        o_job.eoi   = i_in.end_of_input;
        o_job.cnt   = r_cnt;
        o_job.bsel  = r_bsel;
        if (acc) begin
            if (i_in.end_of_input || is_nl) begin
                o_push = 1'b1;
                n_cnt  = '0;
                n_bsel = r_bsel + 1'b1;
            end else if ((r_cnt == '0) && (i_in.char_in == CH_GT)) begin
                // leading quote mark dropped
            end else if (r_cnt < CNT_W'(LINE_CHARS)) begin
                o_wr.we = 1'b1;
                n_cnt   = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_bsel <= '0;
        end else begin
            r_cnt  <= n_cnt;
            r_bsel <= n_bsel;
        end
    end
endmodule

### sv/uud_queue.sv
// ----------------------------------------------------------------------------
// uud_queue
// Short FIFO of line jobs between the front and the back.
// ----------------------------------------------------------------------------
module uud_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  uud_pkg::t_job i_job,
    input  logic          i_pop,
    output uud_pkg::t_job o_job,
    output logic          o_full,
    output logic          o_empty
);
    import uud_pkg::*;

    t_job               r_q [Q_DEPTH];
    logic [Q_IDX_W-1:0] r_wp, r_rp;
    logic [Q_NUM_W-1:0] r_num;

    assign o_job   = r_q[r_rp];
    assign o_full  = (r_num == Q_NUM_W'(Q_DEPTH));
    assign o_empty = (r_num == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_num <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == Q_IDX_W'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == Q_IDX_W'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_num <= r_num + 1'b1;
            end else if (!i_push && i_pop) begin
                r_num <= r_num - 1'b1;
            end
        end
    end
endmodule

### sv/uud_back.sv
// ----------------------------------------------------------------------------
// uud_back
// Interprets one stored line at a time: reads the header characters,
// classifies the line and decodes its sextets into bytes.
// ----------------------------------------------------------------------------
module uud_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  uud_pkg::t_job         i_job,
    output logic                  o_pop,
    output logic                  o_re,
    output logic [uud_pkg::ADDR_W-1:0] o_raddr,
    input  logic [7:0]            i_rdata,
    uud_out_if.source             o_out
);
    import uud_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HRD   = 3'd1;
    localparam logic [2:0] S_HUSE  = 3'd2;
    localparam logic [2:0] S_CLASS = 3'd3;
    localparam logic [2:0] S_ONE   = 3'd4;
    localparam logic [2:0] S_DRD   = 3'd5;
    localparam logic [2:0] S_DUSE  = 3'd6;
    localparam logic [2:0] S_TAIL  = 3'd7;

    localparam logic [1:0] PH_SEEK = 2'd0;
    localparam logic [1:0] PH_BODY = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    localparam logic [POS_W-1:0] HDR_LAST = POS_W'(4);

    logic [2:0]       r_st, n_st;
    logic [1:0]       r_phase, n_phase;
    t_job             r_job, n_job;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [4:0][7:0]  r_hdr, n_hdr;
    logic [5:0]       r_rem, n_rem;
    logic [1:0]       r_j, n_j;
    logic [5:0]       r_prev, n_prev;
    logic [2:0]       r_kind1, n_kind1;
    logic             r_last1, n_last1;

    // output register
    logic       r_ov;
    logic [2:0] r_kind;
    logic [7:0] r_byte;
    logic       r_last;
    logic       can_emit, e;
    logic [2:0] e_kind;
    logic [7:0] e_byte;
    logic       e_last;

    logic [7:0] ch, diff, c0, c1, c2, c3, c4, lenfull;
    logic [5:0] sext;
    logic       m_begin, m_end, m_marker, m_zero, m_illegal;

    assign can_emit = !r_ov || o_out.ready;

    // past the stored characters: terminator, then blanks
    always_comb begin
        if (r_pos < POS_W'(r_job.cnt)) begin
            ch = i_rdata;
        end else if (r_pos == POS_W'(r_job.cnt)) begin
            ch = CH_NUL;
        end else begin
            ch = CH_SP;
        end
    end
    assign diff = ch - CH_SP;
    assign sext = diff[5:0];

    assign c0 = r_hdr[4];
    assign c1 = r_hdr[3];
    assign c2 = r_hdr[2];
    assign c3 = r_hdr[1];
    assign c4 = r_hdr[0];
    assign lenfull   = c0 - CH_SP;
    assign m_begin   = (c0 == CH_B) && (c1 == CH_E) && (c2 == CH_G) && (c3 == CH_I)
                       && (c4 == CH_N);
    assign m_end     = (c0 == CH_E) && (c1 == CH_N) && (c2 == CH_D) && (c3 == CH_NUL);
    assign m_marker  = (c0 == CH_DASH) && (c1 == CH_DASH);
    assign m_zero    = (c0 == CH_BTICK) || (c0 == CH_SP);
    assign m_illegal = (c0 != CH_BTICK)
                       && ((c0 < CH_SP) || (c0 >= CH_HIGH) || (lenfull > MAX_LEN));

    assign o_re    = (r_st == S_HRD) || (r_st == S_DRD);
    assign o_raddr = {r_job.bsel, r_pos[SLOT_W-1:0]};

    always_comb begin
        n_st    = r_st;
        n_phase = r_phase;
        n_job   = r_job;
        n_pos   = r_pos;
        n_hdr   = r_hdr;
        n_rem   = r_rem;
        n_j     = r_j;
        n_prev  = r_prev;
        n_kind1 = r_kind1;
        n_last1 = r_last1;
        o_pop   = 1'b0;
        e       = 1'b0;
        e_kind  = K_DATA;
        e_byte  = '0;
        e_last  = 1'b0;
        case (r_st)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_job = i_job;
                    if (r_phase == PH_DONE) begin
                        n_st = S_IDLE;
                    end else if (i_job.eoi && (i_job.cnt == '0)) begin
                        n_st = S_TAIL;
                    end else begin
                        n_pos = '0;
                        n_st  = S_HRD;
                    end
                end
            end
            S_HRD: begin
                n_st = S_HUSE;
            end
            S_HUSE: begin
                n_hdr = {r_hdr[3:0], ch};
                if (r_pos == HDR_LAST) begin
                    n_st = S_CLASS;
                end else begin
                    n_pos = r_pos + 1'b1;
                    n_st  = S_HRD;
                end
            end
            S_CLASS: begin
                if (r_phase == PH_SEEK) begin
                    if (m_begin) begin
                        n_phase = PH_BODY;
                    end
                    n_st = S_TAIL;
                end else if (m_end || m_zero) begin
                    n_kind1 = K_FINISHED;
                    n_last1 = 1'b1;
                    n_phase = PH_DONE;
                    n_st    = S_ONE;
                end else if (m_marker) begin
                    n_kind1 = K_MARKER;
                    n_last1 = !r_job.eoi;
                    n_st    = S_ONE;
                end else if (m_illegal) begin
                    n_kind1 = K_ILLEGAL;
                    n_last1 = !r_job.eoi;
                    n_st    = S_ONE;
                end else begin
                    n_rem = lenfull[5:0];
                    n_pos = POS_W'(1);
                    n_j   = '0;
                    n_st  = S_DRD;
                end
            end
            S_ONE: begin
                if (can_emit) begin
                    e      = 1'b1;
                    e_kind = r_kind1;
                    e_last = r_last1;
                    n_st   = S_TAIL;
                end
            end
            S_DRD: begin
                n_st = S_DUSE;
            end
            S_DUSE: begin
                if (r_j == 2'd0) begin
                    n_prev = sext;
                    n_j    = 2'd1;
                    n_pos  = r_pos + 1'b1;
                    n_st   = S_DRD;
                end else if (can_emit) begin
                    e      = 1'b1;
                    e_kind = K_DATA;
                    e_last = (r_rem == 6'd1) && !r_job.eoi;
                    case (r_j)
                        2'd1:    e_byte = {r_prev, sext[5:4]};
                        2'd2:    e_byte = {r_prev[3:0], sext[5:2]};
                        2'd3:    e_byte = {r_prev[1:0], sext};
                        default: e_byte = '0;
                    endcase
                    n_prev = sext;
                    n_rem  = r_rem - 1'b1;
                    if (r_rem == 6'd1) begin
                        n_st = S_TAIL;
                    end else begin
                        n_j   = (r_j == 2'd3) ? 2'd0 : r_j + 1'b1;
                        n_pos = r_pos + 1'b1;
                        n_st  = S_DRD;
                    end
                end
            end
            S_TAIL: begin
                // end of input: report premature end unless already finished
                if (r_job.eoi && (r_phase != PH_DONE)) begin
                    if (can_emit) begin
                        e       = 1'b1;
                        e_kind  = K_PREMATURE;
                        e_last  = 1'b1;
                        n_phase = PH_DONE;
                        n_st    = S_IDLE;
                    end
                end else begin
                    n_st = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_phase <= PH_SEEK;
            r_ov    <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_phase <= n_phase;
            if (e) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_job   <= n_job;
        r_pos   <= n_pos;
        r_hdr   <= n_hdr;
        r_rem   <= n_rem;
        r_j     <= n_j;
        r_prev  <= n_prev;
        r_kind1 <= n_kind1;
        r_last1 <= n_last1;
        if (e) begin
            r_kind <= e_kind;
            r_byte <= e_byte;
            r_last <= e_last;
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.kind      = r_kind;
    assign o_out.data_byte = r_byte;
    assign o_out.last      = r_last;
endmodule

### sv/uudecode_body_stream.sv
// ----------------------------------------------------------------------------
// uudecode_body_stream
// uudecode body decoder: line gathering front, job queue, line interpreter.
// ----------------------------------------------------------------------------
// Throughput: one character request per cycle while the two-entry line queue
// has room; line ends are absorbed by the queue and four line buffers.
// Back: each line's header characters are read from its line buffer, then, for
// a data line, one line-RAM read per line character yields its data bytes.
// Reset: synchronous, active low; clears control state, line RAM not cleared.
module uudecode_body_stream (
    input  logic       i_clk,
    input  logic       i_rst_n,
    uud_in_if.sink     i_in,
    uud_out_if.source  o_out
);
    import uud_pkg::*;

    t_wr              wr;
    t_job             push_job, head_job;
    logic             push, pop, full, empty;
    logic             re;
    logic [ADDR_W-1:0] raddr;
    logic [7:0]       rdata;

    uud_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_wr    (wr),
        .o_push  (push),
        .o_job   (push_job),
        .i_full  (full)
    );

    uud_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (full),
        .o_empty (empty)
    );

    uud_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (wr.we),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    uud_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_re    (re),
        .o_raddr (raddr),
        .i_rdata (rdata),
        .o_out   (o_out)
    );
endmodule

### sim/tb_uudecode_body_stream.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uudecode_body_stream
// Self-checking bench for the uudecode body decoder. A driver plays a queued
// character stream (directed lines, then random well-formed and broken
// lines, then one of several stream endings) into the request channel. A
// line-level predictor builds the expected results and a monitor checks them
// in order. Sender gaps and receiver stalls change over four traffic phases.
// ----------------------------------------------------------------------------
module tb_uudecode_body_stream;
    import uud_pkg::*;

    localparam int RANDOM_REQS = 320;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 400;

    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
    } t_char_req;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic       last;
    } t_dec_res;

    typedef enum logic [1:0] {PH_SEEK, PH_BODY, PH_DONE} t_dec_phase;

    logic i_clk = 1'b0;
    logic i_rst_n;

    uud_in_if  in_if ();
    uud_out_if out_if ();

    uudecode_body_stream DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_char_req  char_q[$];
    t_dec_res   decoded_q[$];
    t_char_req  cur_req;
    int         reqs_total;
    int         accepted_cnt = 0;
    int         checked_cnt  = 0;
    int         err_cnt      = 0;
    int         line_cnt     = 0;
    int         cycle_cnt    = 0;
    string      end_name;

    // predictor state
    t_dec_phase dec_phase = PH_SEEK;
    logic [7:0] line_buf[LINE_CHARS];
    int         line_len  = 0;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic logic [7:0] line_at(int pos);
        if (pos < line_len)
            return line_buf[pos];
        if (pos == line_len)
            return CH_NUL;  // terminator slot, decodes as sextet 32
        return CH_SP;
    endfunction

    function automatic logic [5:0] sextet_at(int pos);
        logic [7:0] d;
        d = line_at(pos) - CH_SP;
        return d[5:0];
    endfunction

    task automatic push_result(logic [2:0] kind, logic [7:0] data_byte);
        decoded_q.push_back('{kind: kind, data_byte: data_byte, last: 1'b0});
    endtask

    task automatic interpret_line();
        logic [7:0] b;
        logic [5:0] s0, s1, s2, s3;
        int len, rem, g, base;
        if (dec_phase == PH_SEEK) begin
            if (line_at(0) == CH_B && line_at(1) == CH_E && line_at(2) == CH_G &&
                line_at(3) == CH_I && line_at(4) == CH_N)
                dec_phase = PH_BODY;
            return;
        end
        if (dec_phase != PH_BODY)
            return;
        if (line_at(0) == CH_E && line_at(1) == CH_N && line_at(2) == CH_D &&
            line_at(3) == CH_NUL) begin
            dec_phase = PH_DONE;
            push_result(K_FINISHED, 8'h00);
            return;
        end
        if (line_at(0) == CH_DASH && line_at(1) == CH_DASH) begin
            push_result(K_MARKER, 8'h00);
            return;
        end
        b = line_at(0);
        if (b == CH_BTICK) begin
            len = 0;
        end else if (b < CH_SP || b >= CH_HIGH) begin
            push_result(K_ILLEGAL, 8'h00);
            return;
        end else begin
            len = int'(b - CH_SP);
        end
        if (len > MAX_LEN) begin
            push_result(K_ILLEGAL, 8'h00);
            return;
        end
        if (len == 0) begin
            dec_phase = PH_DONE;
            push_result(K_FINISHED, 8'h00);
            return;
        end
        rem = len;
        g   = 0;
        while (rem > 0) begin
            base = 1 + 4 * g;
            s0 = sextet_at(base);
            s1 = sextet_at(base + 1);
            s2 = sextet_at(base + 2);
            s3 = sextet_at(base + 3);
            push_result(K_DATA, {s0, s1[5:4]});
            if (rem >= 2)
                push_result(K_DATA, {s1[3:0], s2[5:2]});
            if (rem >= 3)
                push_result(K_DATA, {s2[1:0], s3});
            rem = (rem > 3) ? rem - 3 : 0;
            g++;
        end
    endtask

    task automatic decode_step(logic [7:0] c, logic eoi);
        int n0;
        n0 = decoded_q.size();
        if (dec_phase == PH_DONE)
            return;
        if (eoi) begin
            if (line_len > 0)
                interpret_line();
            if (dec_phase != PH_DONE)
                push_result(K_PREMATURE, 8'h00);
            dec_phase = PH_DONE;
            line_len  = 0;
        end else if (c == CH_LF || c == CH_CR) begin
            interpret_line();
            line_len = 0;
        end else if (line_len == 0 && c == CH_GT) begin
            // leading quote mark dropped
        end else if (line_len < LINE_CHARS) begin
            line_buf[line_len] = c;
            line_len++;
        end
        if (decoded_q.size() > n0)
            decoded_q[decoded_q.size() - 1].last = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // stream builders
    // ------------------------------------------------------------------------
    task automatic put_char(logic [7:0] c);
        char_q.push_back('{ch: c, eoi: 1'b0});
    endtask

    task automatic put_eoi();
        char_q.push_back('{ch: 8'($urandom_range(255)), eoi: 1'b1});
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++)
            put_char(s[i]);
    endtask

    task automatic end_line();
        int r;
        r = $urandom_range(9);
        if (r < 6) begin
            put_char(CH_LF);
        end else if (r < 9) begin
            put_char(CH_CR);
        end else begin
            // CR LF: the empty second line is an illegal length in the body
            put_char(CH_CR);
            put_char(CH_LF);
        end
        line_cnt++;
    endtask

    function automatic logic [7:0] rand_text_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (c == CH_LF || c == CH_CR);
        return c;
    endfunction

    function automatic logic [7:0] sextet_char(logic [5:0] s);
        if (s == 6'd0 && $urandom_range(1) == 1)
            return CH_BTICK;
        return CH_SP + s;
    endfunction

    // length char plus groups of four; some lines are cut, padded or corrupted
    task automatic put_data_line(bit terminate);
        logic [7:0] enc[$];
        logic [7:0] b0, b1, b2;
        int n, cut;
        n = ($urandom_range(9) == 0) ? 63 : $urandom_range(1, 45);
        enc.push_back(CH_SP + 8'(n));
        for (int g = 0; g < (n + 2) / 3; g++) begin
            b0 = 8'($urandom_range(255));
            b1 = 8'($urandom_range(255));
            b2 = 8'($urandom_range(255));
            enc.push_back(sextet_char(b0[7:2]));
            enc.push_back(sextet_char({b0[1:0], b1[7:4]}));
            enc.push_back(sextet_char({b1[3:0], b2[7:6]}));
            enc.push_back(sextet_char(b2[5:0]));
        end
        case ($urandom_range(9))
            0: begin
                cut = $urandom_range(1, enc.size() - 1);
                repeat (cut) void'(enc.pop_back());
            end
            1: repeat ($urandom_range(1, 6)) enc.push_back(sextet_char(6'($urandom_range(63))));
            2: enc[$urandom_range(1, enc.size() - 1)] = rand_text_byte();
            default: ;
        endcase
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 2)) put_char(CH_GT);
        foreach (enc[i])
            put_char(enc[i]);
        if (terminate)
            end_line();
    endtask

    // garbage line that can never finish the stream
    task automatic put_noise_line();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (c == CH_LF || c == CH_CR || c == CH_SP || c == CH_BTICK ||
               c == CH_GT || c == CH_E);
        put_char(c);
        repeat ($urandom_range(0, 70)) put_char(rand_text_byte());
        end_line();
    endtask

    task automatic build_stream();
        int r;
        // seek phase: marker ignored, quoted begin line ended by CR
        put_text("--");
        put_char(CH_LF);
        put_text(">>begin");
        put_char(CH_CR);
        // body: empty line, high and control length chars, marker
        put_char(CH_LF);
        put_char(CH_HIGH);
        put_char(CH_LF);
        put_char(8'h1F);
        put_char(CH_LF);
        put_text("--");
        put_char(CH_LF);
        // two-byte line built from extreme characters
        put_char(8'h22);
        put_char(8'hFF);
        put_char(8'h00);
        put_char(8'h7F);
        put_char(CH_LF);

        while (char_q.size() < RANDOM_REQS) begin
            r = $urandom_range(99);
            if (r < 60) begin
                put_data_line(1'b1);
            end else if (r < 70) begin
                put_noise_line();
            end else if (r < 78) begin
                put_text("--");
                repeat ($urandom_range(0, 10)) put_char(rand_text_byte());
                end_line();
            end else if (r < 85) begin
                // almost an end line
                if ($urandom_range(1) == 1) begin
                    put_text("en");
                end else begin
                    // fourth char nonzero and never a line end
                    put_text("end");
                    put_char(rand_text_byte() | 8'h10);
                end
                end_line();
            end else if (r < 90) begin
                end_line();
            end else begin
                // length above 63, still below the high range
                put_char(8'($urandom_range(8'h61, 8'h7F)));
                repeat ($urandom_range(0, 8)) put_char(rand_text_byte());
                end_line();
            end
        end

        case ($urandom_range(6))
            0: begin
                end_name = "end line";
                put_text("end");
                end_line();
            end
            1: begin
                end_name = "backtick length line";
                put_char(CH_BTICK);
                repeat ($urandom_range(0, 5)) put_char(rand_text_byte());
                end_line();
            end
            2: begin
                end_name = "space length line";
                put_char(CH_SP);
                end_line();
            end
            3: begin
                end_name = "end line closed by end of input";
                put_text("end");
                put_eoi();
            end
            4: begin
                end_name = "data line cut by end of input";
                put_data_line(1'b0);
                put_eoi();
            end
            5: begin
                end_name = "end of input between lines";
                put_eoi();
            end
            default: begin
                end_name = "end line with stored NUL";
                put_text("end");
                put_char(CH_NUL);
                end_line();
            end
        endcase
        // ignored once done
        repeat (3) put_char(8'($urandom_range(255)));
        put_eoi();
    endtask

    // ------------------------------------------------------------------------
    // traffic phases: free-running, sender gaps, receiver stalls, both light
    // ------------------------------------------------------------------------
    function automatic int traffic_mode();
        if (reqs_total == 0)
            return 0;
        return (accepted_cnt * 4) / reqs_total;
    endfunction

    function automatic int sender_gap_pct();
        case (traffic_mode())
            1: return 66;
            3: return 13;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case (traffic_mode())
            2: return 66;
            3: return 13;
            default: return 0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_req
        logic taken;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            taken = in_if.valid && in_if.ready;
            if (taken) begin
                decode_step(cur_req.ch, cur_req.eoi);
                accepted_cnt++;
            end
            if (!in_if.valid || taken) begin
                if (char_q.size() > 0 && $urandom_range(99) >= sender_gap_pct()) begin
                    cur_req = char_q.pop_front();
                    in_if.valid        <= 1'b1;
                    in_if.char_in      <= cur_req.ch;
                    in_if.end_of_input <= cur_req.eoi;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        err_cnt++;
        if (err_cnt <= 40)
            $display("[%0t] result %0d: %s got %0h, expected %0h",
                     $time, checked_cnt, what, got, want);
    endtask

    always @(posedge i_clk) begin : check_res
        t_dec_res want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch("unexpected result, kind", out_if.kind, 0);
                end else begin
                    want = decoded_q.pop_front();
                    if (out_if.kind !== want.kind)
                        report_mismatch("kind", out_if.kind, want.kind);
                    if (out_if.data_byte !== want.data_byte)
                        report_mismatch("data_byte", out_if.data_byte, want.data_byte);
                    if (out_if.last !== want.last)
                        report_mismatch("last", out_if.last, want.last);
                    checked_cnt++;
                end
            end
            out_if.ready <= ($urandom_range(99) >= receiver_stall_pct());
        end
    end

    // timeout
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout: %0d of %0d requests taken, %0d results outstanding",
                     accepted_cnt, reqs_total, decoded_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.char_in      = 8'h00;
        in_if.end_of_input = 1'b0;
        out_if.ready       = 1'b0;
        reqs_total         = 0;
        build_stream();
        reqs_total = char_q.size();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (accepted_cnt == reqs_total);
        while (decoded_q.size() > 0)
            @(posedge i_clk);
        // catch any stray results after the last expected one
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d character requests over %0d lines, %0d results checked.",
                 reqs_total, line_cnt, checked_cnt);
        $display("Stream ended by: %s", end_name);
        if (err_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
